/* rtl/psg_pkg.sv */
package psg_pkg;

    // Operation codes carried by an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DRUM_MODE     = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_ENABLE = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd2;

    localparam logic [1:0] NOISE_CHANNEL = 2'd3;

    localparam logic [15:0] SHIFTER_RESET = 16'h8000;
    localparam logic [15:0] WHITE_TAPS    = 16'h0009;
    localparam logic [15:0] PERIOD_RESET  = 16'd75;
    localparam logic signed [17:0] SAMPLE_MIN = -18'sd131072;

    // Cycle run shared by all counters.
    typedef struct packed {
        logic       run;
        logic [7:0] cycles;
    } run_t;

    // Tone period write: low nibble or upper six bits.
    typedef struct packed {
        logic       lo_we;
        logic       hi_we;
        logic [5:0] data;
    } tone_wr_t;

    // Noise control write.
    typedef struct packed {
        logic       we;
        logic [2:0] data;
    } noise_wr_t;

endpackage

/* rtl/psg_tone.sv */
module psg_tone
    import psg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  tone_wr_t   wr,
    input  run_t       run,
    output logic [9:0] period,
    output logic       neg_next
);

    logic [9:0]         period_reg, period_next;
    logic [15:0]        count_reg, count_next;
    logic               neg_reg;
    logic signed [16:0] left;
    logic               frozen;
    logic               expire;

    assign left   = $signed({1'b0, count_reg}) - $signed({9'b0, run.cycles});
    assign frozen = (count_reg == 16'd0) && (period_reg == 10'd0);
    assign expire = left[16] || (left == 17'sd0);

    always_comb begin
        period_next = period_reg;
        count_next  = count_reg;
        neg_next    = neg_reg;
        if (wr.lo_we) begin
            period_next = {period_reg[9:4], wr.data[3:0]};
        end else if (wr.hi_we) begin
            period_next = {wr.data, period_reg[3:0]};
        end
        if (run.run && !frozen) begin
            if (expire) begin
                // Reload with period times 16; any overshoot is dropped.
                count_next = {2'b00, period_reg, 4'b0000};
                neg_next   = !neg_reg;
            end else begin
                count_next = left[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            count_reg  <= '0;
            neg_reg    <= 1'b0;
        end else begin
            period_reg <= period_next;
            count_reg  <= count_next;
            neg_reg    <= neg_next;
        end
    end

    assign period = period_reg;

endmodule

/* rtl/psg_noise.sv */
module psg_noise
    import psg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  noise_wr_t  wr,
    input  run_t       run,
    input  logic       drum_mode,
    input  logic [9:0] tone2_period,
    output logic       neg_next
);

    logic [15:0]        count_reg, count_next;
    logic [15:0]        shift_reg, shift_next;
    logic [1:0]         rate_reg, rate_next;
    logic               white_reg, white_next;
    logic               toggle_reg, toggle_next;
    logic               neg_reg;
    logic signed [16:0] left;
    logic               expire;
    logic [15:0]        reload;
    logic [15:0]        taps;
    logic               feed;

    assign left   = $signed({1'b0, count_reg}) - $signed({9'b0, run.cycles});
    assign expire = left[16] || (left == 17'sd0);
    assign taps   = shift_reg & WHITE_TAPS;
    assign feed   = white_reg ? (taps[0] ^ taps[3]) : shift_reg[0];

    always_comb begin
        case (rate_reg)
            2'd0:    reload = drum_mode ? 16'd16 : 16'd256;
            2'd1:    reload = drum_mode ? 16'd32 : 16'd512;
            2'd2:    reload = drum_mode ? 16'd64 : 16'd1024;
            default: reload = {2'b00, tone2_period, 4'b0000};
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        shift_next  = shift_reg;
        rate_next   = rate_reg;
        white_next  = white_reg;
        toggle_next = toggle_reg;
        neg_next    = neg_reg;
        if (wr.we) begin
            shift_next = SHIFTER_RESET;
            rate_next  = wr.data[1:0];
            white_next = wr.data[2];
        end
        if (run.run) begin
            if (expire) begin
                count_next  = reload;
                toggle_next = !toggle_reg;
                // The shifter advances on every second expiry.
                if (!toggle_reg) begin
                    neg_next   = !shift_reg[0];
                    shift_next = {feed, shift_reg[15:1]};
                end
            end else begin
                count_next = left[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            shift_reg  <= SHIFTER_RESET;
            rate_reg   <= '0;
            white_reg  <= 1'b0;
            toggle_reg <= 1'b0;
            neg_reg    <= 1'b0;
        end else begin
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            rate_reg   <= rate_next;
            white_reg  <= white_next;
            toggle_reg <= toggle_next;
            neg_reg    <= neg_next;
        end
    end

endmodule

/* rtl/psg_three_tone_one_noise.sv */
// Three-tone, one-noise sound generator.
// An accepted item waits in the input register until the result register can take its output;
// a run item that fires a mixer sample has it captured in the result register for the m_ channel.
// Throughput: one item per cycle, set by the single pass from the input register
// to the state and result registers; the input side stalls only while a sample waits.
// Reset (aresetn, synchronous, active low) returns all channel state and config to defaults.
module psg_three_tone_one_noise
    import psg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [7:0]        s_write_value,
    input  logic [7:0]        s_cycle_count,

    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [4:0] m_tone_a_level,
    output logic signed [4:0] m_tone_b_level,
    output logic signed [4:0] m_tone_c_level,
    output logic signed [4:0] m_noise_level
);

    // Configuration registers.
    logic        drum_mode_reg;
    logic        sample_enable_reg;
    logic [15:0] sample_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drum_mode_reg     <= 1'b0;
            sample_enable_reg <= 1'b0;
            sample_period_reg <= PERIOD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DRUM_MODE:     drum_mode_reg     <= cfg_wdata[0];
                CFG_SAMPLE_ENABLE: sample_enable_reg <= cfg_wdata[0];
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register. The item held here is processed in one pass as soon
    // as the result register can take whatever it produces.
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_value_reg;
    logic [7:0] in_cycles_reg;
    logic       step;

    assign step    = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg     <= s_operation;
            in_value_reg  <= s_write_value;
            in_cycles_reg <= s_cycle_count;
        end
    end

    // Register write decode. A byte with bit 7 set latches a new channel and
    // type and carries four data bits; any other byte carries six data bits
    // for the target latched before.
    logic [1:0] latch_ch_reg, latch_ch_next;
    logic       latch_vol_reg, latch_vol_next;
    logic       wr_item;
    logic       is_latch;
    logic [5:0] wr_data;
    logic [3:0] volume_reg [4];

    tone_wr_t  tone_wr [3];
    noise_wr_t noise_wr;
    run_t      run;

    assign wr_item = step && (in_op_reg == OP_WRITE);
    assign is_latch = in_value_reg[7];

    always_comb begin
        latch_ch_next  = latch_ch_reg;
        latch_vol_next = latch_vol_reg;
        wr_data        = in_value_reg[5:0];
        if (is_latch) begin
            latch_ch_next  = in_value_reg[6:5];
            latch_vol_next = in_value_reg[4];
            wr_data        = {2'b00, in_value_reg[3:0]};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tone_wr[i].lo_we = wr_item && !latch_vol_next && (latch_ch_next == 2'(i))
                               && is_latch;
            tone_wr[i].hi_we = wr_item && !latch_vol_next && (latch_ch_next == 2'(i))
                               && !is_latch;
            tone_wr[i].data  = wr_data;
        end
        noise_wr.we   = wr_item && !latch_vol_next && (latch_ch_next == NOISE_CHANNEL);
        noise_wr.data = wr_data[2:0];
        run.run       = step && (in_op_reg == OP_RUN);
        run.cycles    = in_cycles_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_ch_reg  <= '0;
            latch_vol_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                volume_reg[i] <= 4'hF;
            end
        end else if (wr_item) begin
            latch_ch_reg  <= latch_ch_next;
            latch_vol_reg <= latch_vol_next;
            if (latch_vol_next) begin
                volume_reg[latch_ch_next] <= wr_data[3:0];
            end
        end
    end

    // Tone and noise channels.
    logic [9:0] period [3];
    logic       neg_next [4];

    for (genvar g = 0; g < 3; g++) begin : g_tone
        psg_tone u_tone (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr       (tone_wr[g]),
            .run      (run),
            .period   (period[g]),
            .neg_next (neg_next[g])
        );
    end

    psg_noise u_noise (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr           (noise_wr),
        .run          (run),
        .drum_mode    (drum_mode_reg),
        .tone2_period (period[2]),
        .neg_next     (neg_next[3])
    );

    // Sample countdown: while sampling is enabled, drops by the cycles of each
    // run item and saturates at its most negative value. At or below zero the
    // period is added back, keeping the overshoot, and one mixer sample is emitted.
    logic signed [17:0] sample_cnt_reg;
    logic signed [18:0] sample_diff;
    logic signed [17:0] sample_sat;
    logic               fire;

    assign sample_diff = {sample_cnt_reg[17], sample_cnt_reg} - $signed({11'b0, in_cycles_reg});
    assign sample_sat  = (sample_diff < $signed({SAMPLE_MIN[17], SAMPLE_MIN}))
                         ? SAMPLE_MIN : sample_diff[17:0];
    assign fire        = run.run && sample_enable_reg && (sample_sat <= 18'sd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_cnt_reg <= '0;
        end else if (run.run && sample_enable_reg) begin
            if (sample_sat <= 18'sd0) begin
                sample_cnt_reg <= sample_sat + $signed({2'b00, sample_period_reg});
            end else begin
                sample_cnt_reg <= sample_sat;
            end
        end
    end

    // Mixer levels: polarity times (15 minus volume), from the polarity the
    // same run item leaves behind.
    logic signed [4:0] level_next [4];

    always_comb begin
        logic [4:0] mag;
        for (int i = 0; i < 4; i++) begin
            mag           = {1'b0, 4'hF - volume_reg[i]};
            level_next[i] = neg_next[i] ? $signed(5'd0 - mag) : $signed(mag);
        end
    end

    // Result register.
    logic              m_valid_reg;
    logic signed [4:0] level_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            for (int i = 0; i < 4; i++) begin
                level_reg[i] <= level_next[i];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_tone_a_level = level_reg[0];
    assign m_tone_b_level = level_reg[1];
    assign m_tone_c_level = level_reg[2];
    assign m_noise_level  = level_reg[3];

endmodule
